/* design/assert_macros.svh */
// Assertion helpers included by the top-level design file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define TC2U8_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset cycles included.
`define TC2U8_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* design/tc2u8_pkg.sv */
`timescale 1ns / 1ps

package tc2u8_pkg;

    // Control codes of the tape.
    localparam logic [7:0] CODE_LOWER = 8'o072;
    localparam logic [7:0] CODE_UPPER = 8'o074;
    localparam logic [7:0] CODE_RIB_A = 8'o034;
    localparam logic [7:0] CODE_RIB_B = 8'o035;
    localparam logic [6:0] CODE_DOT   = 7'o040;

    // Flag positions inside the mode register.
    localparam int FLAG_UPPER = 0;
    localparam int FLAG_DOT   = 1;

    localparam int MAX_BYTES = 5;

    // One translation table entry: byte count and bytes, first byte lowest.
    typedef struct packed {
        logic [2:0]              len;
        logic [MAX_BYTES*8-1:0]  bytes;
    } t_rom_entry;

    // Table read request from the mode logic.
    typedef struct packed {
        logic       vld;
        logic [7:0] addr;
    } t_rd_req;

    // Registered table read data with its valid bit.
    typedef struct packed {
        logic       vld;
        t_rom_entry entry;
    } t_rd_rsp;

    function automatic t_rom_entry mk(input logic [2:0] n, input logic [39:0] v);
        t_rom_entry e;
        e.len   = n;
        e.bytes = v;
        return e;
    endfunction

    function automatic t_rom_entry mk1(input logic [7:0] b);
        return mk(3'd1, {32'h0, b});
    endfunction

    // Lower case half of the table.
    function automatic t_rom_entry lower_entry(input logic [5:0] c);
        t_rom_entry e;
        logic [7:0] cx;
        cx = {2'b00, c};
        e  = '0;
        case (c)
            6'o00: e = mk1(8'h20);
            6'o20: e = mk1(8'h30);
            6'o21: e = mk1(8'h2F);
            6'o33: e = mk1(8'h2C);
            6'o36: e = mk1(8'h09);
            6'o40: e = mk(3'd2, 40'hB7C2);
            6'o54: e = mk1(8'h2D);
            6'o55: e = mk1(8'h29);
            6'o56: e = mk(3'd3, 40'h9480E2);
            6'o57: e = mk1(8'h28);
            6'o73: e = mk1(8'h2E);
            6'o75: e = mk1(8'h08);
            6'o77: e = mk1(8'h0A);
            default: begin
                // Digits and letters run in contiguous groups.
                if (c >= 6'o01 && c <= 6'o11) begin
                    e = mk1(cx + 8'h30);
                end else if (c >= 6'o22 && c <= 6'o31) begin
                    e = mk1(cx + 8'h61);
                end else if (c >= 6'o41 && c <= 6'o51) begin
                    e = mk1(cx + 8'h49);
                end else if (c >= 6'o61 && c <= 6'o71) begin
                    e = mk1(cx + 8'h30);
                end else begin
                    e = '0;
                end
            end
        endcase
        return e;
    endfunction

    // Upper case half of the table.
    function automatic t_rom_entry upper_entry(input logic [5:0] c);
        t_rom_entry e;
        logic [7:0] cx;
        cx = {2'b00, c};
        e  = '0;
        case (c)
            6'o00: e = mk1(8'h20);
            6'o01: e = mk1(8'h22);
            6'o02: e = mk1(8'h27);
            6'o03: e = mk1(8'h7E);
            6'o04: e = mk(3'd3, 40'h838AE2);
            6'o05: e = mk(3'd3, 40'hA888E2);
            6'o06: e = mk(3'd3, 40'hA788E2);
            6'o07: e = mk1(8'h3C);
            6'o10: e = mk1(8'h3E);
            6'o11: e = mk(3'd3, 40'h9186E2);
            6'o20: e = mk(3'd3, 40'h9286E2);
            6'o21: e = mk1(8'h3F);
            6'o33: e = mk1(8'h3D);
            6'o36: e = mk1(8'h09);
            6'o40: e = mk1(8'h5F);
            6'o54: e = mk1(8'h2B);
            6'o55: e = mk1(8'h5D);
            6'o56: e = mk1(8'h7C);
            6'o57: e = mk1(8'h5B);
            6'o73: e = mk(3'd2, 40'h97C3);
            6'o75: e = mk1(8'h08);
            6'o77: e = mk1(8'h0A);
            default: begin
                // Capital letters run in contiguous groups.
                if (c >= 6'o22 && c <= 6'o31) begin
                    e = mk1(cx + 8'h41);
                end else if (c >= 6'o41 && c <= 6'o51) begin
                    e = mk1(cx + 8'h29);
                end else if (c >= 6'o61 && c <= 6'o71) begin
                    e = mk1(cx + 8'h10);
                end else begin
                    e = '0;
                end
            end
        endcase
        return e;
    endfunction

    // Full 256-entry table; the dotted halves differ from the plain ones
    // only in a few places.
    function automatic t_rom_entry rom_entry(input logic [7:0] idx);
        t_rom_entry base;
        t_rom_entry e;
        base = idx[6] ? upper_entry(idx[5:0]) : lower_entry(idx[5:0]);
        e    = base;
        if (idx[7]) begin
            case (idx[6:0])
                7'o000: e = mk(3'd2, 40'hB7C2);
                7'o021: e = mk(3'd4, 40'hB7CCB7C2);
                7'o033: e = mk1(8'h3B);
                7'o036: e = mk(3'd3, 40'h09B7C2);
                7'o043: e = mk(3'd2, 40'h80C5);
                7'o073: e = mk1(8'h3A);
                7'o077: e = mk(3'd3, 40'h0AB7C2);
                7'o100: e = mk(3'd2, 40'hB7C2);
                7'o136: e = mk(3'd3, 40'h09B7C2);
                7'o140: e = mk(3'd4, 40'hB2CCB7C2);
                7'o143: e = mk(3'd2, 40'hBFC4);
                7'o156: e = mk(3'd5, 40'h9283E2B7C2);
                7'o177: e = mk(3'd3, 40'h0AB7C2);
                default: e = base;
            endcase
        end
        return e;
    endfunction

endpackage

/* design/tape_code_to_utf8_converter_unit.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Converts six-bit tape codes to UTF-8 text. One tape code item is taken per
// cycle while o_s_tready is high; shift, ribbon and center-dot codes produce no
// output, while a character produces the zero to five UTF-8 bytes of its table
// entry, one byte per cycle while the receiver is ready, with tlast on the final
// byte. While the serializer is busy, the next character waits in the
// registered translation table read, and input stalls once that is full. The
// first byte passes through the table read register and then the output
// serializer register. No clearing pass is needed.
module tape_code_to_utf8_converter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] tape_code
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] utf8_byte
    output logic       o_m_tlast    // last_byte
);

    tc2u8_pkg::t_rd_req rd_req;
    tc2u8_pkg::t_rd_rsp rd_rsp;
    logic               ser_free;
    logic               accept;
    logic               consume;

    // A new item may enter whenever the table read register can advance.
    assign o_s_tready = !rd_rsp.vld || ser_free;
    assign accept     = i_s_tvalid & o_s_tready;
    assign consume    = rd_rsp.vld & ser_free;

    tc2u8_mode u_mode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_code   (i_s_tdata),
        .o_rd_req (rd_req)
    );

    tc2u8_rom u_rom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_req  (rd_req),
        .i_consume (consume),
        .o_rd_rsp  (rd_rsp)
    );

    tc2u8_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_rsp   (rd_rsp),
        .i_m_tready (i_m_tready),
        .o_free     (ser_free),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Checks on the internal handoff between the stages.
    `TC2U8_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !o_m_tvalid, "output valid after reset")
    `TC2U8_ASSERT(a_rd_latency, rd_req.vld |=> rd_rsp.vld, "table read data not valid")
    `TC2U8_ASSERT(a_rd_hold, rd_rsp.vld && !ser_free |=> rd_rsp.vld && $stable(rd_rsp.entry), "table data lost while stalled")
    `TC2U8_ASSERT(a_ser_load, consume && rd_rsp.entry.len != 3'd0 |=> o_m_tvalid, "string not loaded")

endmodule

/* design/tc2u8_mode.sv */
`timescale 1ns / 1ps

module tc2u8_mode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_code,
    output tc2u8_pkg::t_rd_req  o_rd_req
);

    logic [1:0] r_flags;
    logic [1:0] n_flags;
    logic [7:0] idx;
    logic       emit;

    // Decode the item against the shift and dot flags.
    always_comb begin
        n_flags = r_flags;
        idx     = i_code | {r_flags, 6'b0};
        emit    = 1'b0;
        if (i_code == tc2u8_pkg::CODE_UPPER) begin
            n_flags[tc2u8_pkg::FLAG_UPPER] = 1'b1;
        end else if (i_code == tc2u8_pkg::CODE_LOWER) begin
            n_flags[tc2u8_pkg::FLAG_UPPER] = 1'b0;
        end else if (i_code == tc2u8_pkg::CODE_RIB_A || i_code == tc2u8_pkg::CODE_RIB_B) begin
            n_flags = r_flags;
        end else if (idx[6:0] == tc2u8_pkg::CODE_DOT) begin
            n_flags[tc2u8_pkg::FLAG_DOT] = 1'b1;
        end else begin
            // A character is looked up even when its string is empty.
            n_flags[tc2u8_pkg::FLAG_DOT] = 1'b0;
            emit = 1'b1;
        end
    end

    // Flags change only when an item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= 2'b00;
        end else if (i_accept) begin
            r_flags <= n_flags;
        end
    end

    assign o_rd_req.vld  = i_accept & emit;
    assign o_rd_req.addr = idx;

endmodule

/* design/tc2u8_rom.sv */
`timescale 1ns / 1ps

module tc2u8_rom (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tc2u8_pkg::t_rd_req  i_rd_req,
    input  logic                i_consume,
    output tc2u8_pkg::t_rd_rsp  o_rd_rsp
);

    logic                  r_vld;
    tc2u8_pkg::t_rom_entry r_q;

    // Synchronous table read; the data register holds until a new read.
    always_ff @(posedge i_clk) begin
        if (i_rd_req.vld) begin
            r_q <= tc2u8_pkg::rom_entry(i_rd_req.addr);
        end
    end

    // Read data stays valid until the serializer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_rd_req.vld) begin
            r_vld <= 1'b1;
        end else if (i_consume) begin
            r_vld <= 1'b0;
        end
    end

    assign o_rd_rsp.vld   = r_vld;
    assign o_rd_rsp.entry = r_q;

endmodule

/* design/tc2u8_ser.sv */
`timescale 1ns / 1ps

module tc2u8_ser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tc2u8_pkg::t_rd_rsp  i_rd_rsp,
    input  logic                i_m_tready,
    output logic                o_free,
    output logic                o_m_tvalid,
    output logic [7:0]          o_m_tdata,
    output logic                o_m_tlast
);

    logic                             r_vld;
    logic [2:0]                       r_left;
    logic [tc2u8_pkg::MAX_BYTES*8-1:0] r_bytes;
    logic                             last;

    assign last   = (r_left == 3'd1);
    assign o_free = !r_vld || (i_m_tready && last);

    // Load a new string, or shift out one byte per taken item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_left <= 3'd0;
        end else if (i_rd_rsp.vld && o_free) begin
            r_vld  <= (i_rd_rsp.entry.len != 3'd0);
            r_left <= i_rd_rsp.entry.len;
        end else if (r_vld && i_m_tready) begin
            r_vld  <= !last;
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_rsp.vld && o_free) begin
            r_bytes <= i_rd_rsp.entry.bytes;
        end else if (r_vld && i_m_tready) begin
            r_bytes <= {8'h00, r_bytes[tc2u8_pkg::MAX_BYTES*8-1:8]};
        end
    end

    assign o_m_tvalid = r_vld;
    assign o_m_tdata  = r_bytes[7:0];
    assign o_m_tlast  = last;

endmodule

/* tb/tb_tape_code_to_utf8_converter_unit.sv */
`timescale 1ns / 1ps

// Tracks the shift and center-dot state of the converter, turns each accepted
// tape code into the UTF-8 bytes it must produce and checks the output stream.
class Utf8Scoreboard;
    bit          shift_upper;
    bit          dot_pending;
    bit [8:0]    byte_q[$];      // {last_byte, utf8_byte}, oldest first
    int unsigned errors;
    int unsigned codes_taken;
    int unsigned chars_printed;
    int unsigned blank_chars;
    int unsigned dots_marked;
    int unsigned bytes_checked;

    function new();
        shift_upper   = 1'b0;
        dot_pending   = 1'b0;
        errors        = 0;
        codes_taken   = 0;
        chars_printed = 0;
        blank_chars   = 0;
        dots_marked   = 0;
        bytes_checked = 0;
    endfunction

    // A one-byte string, left aligned.
    function bit [42:0] single(bit [7:0] b);
        return {3'd1, b, 32'h0};
    endfunction

    // String for one table index: byte count in the top three bits, then the
    // bytes in text order, first byte in the highest position.
    function bit [42:0] glyph(bit [7:0] idx);
        bit [5:0]  c;
        bit [42:0] g;
        c = idx[5:0];
        g = '0;
        if (!idx[6]) begin
            case (c)
                6'o00: g = single(8'h20);
                6'o20: g = single(8'h30);
                6'o21: g = single(8'h2F);
                6'o33: g = single(8'h2C);
                6'o36: g = single(8'h09);
                6'o40: g = {3'd2, 40'hC2B7_000000};
                6'o54: g = single(8'h2D);
                6'o55: g = single(8'h29);
                6'o56: g = {3'd3, 40'hE28094_0000};
                6'o57: g = single(8'h28);
                6'o73: g = single(8'h2E);
                6'o75: g = single(8'h08);
                6'o77: g = single(8'h0A);
                default: begin
                    // Digits 1-9 and the letters a-i share the same offset.
                    if ((c >= 6'o01 && c <= 6'o11) || (c >= 6'o61 && c <= 6'o71)) begin
                        g = single(8'h30 + c);
                    end else if (c >= 6'o22 && c <= 6'o31) begin
                        g = single(8'h61 + c);
                    end else if (c >= 6'o41 && c <= 6'o51) begin
                        g = single(8'h49 + c);
                    end
                end
            endcase
        end else begin
            case (c)
                6'o00: g = single(8'h20);
                6'o01: g = single(8'h22);
                6'o02: g = single(8'h27);
                6'o03: g = single(8'h7E);
                6'o04: g = {3'd3, 40'hE28A83_0000};
                6'o05: g = {3'd3, 40'hE288A8_0000};
                6'o06: g = {3'd3, 40'hE288A7_0000};
                6'o07: g = single(8'h3C);
                6'o10: g = single(8'h3E);
                6'o11: g = {3'd3, 40'hE28691_0000};
                6'o20: g = {3'd3, 40'hE28692_0000};
                6'o21: g = single(8'h3F);
                6'o33: g = single(8'h3D);
                6'o36: g = single(8'h09);
                6'o40: g = single(8'h5F);
                6'o54: g = single(8'h2B);
                6'o55: g = single(8'h5D);
                6'o56: g = single(8'h7C);
                6'o57: g = single(8'h5B);
                6'o73: g = {3'd2, 40'hC397_000000};
                6'o75: g = single(8'h08);
                6'o77: g = single(8'h0A);
                default: begin
                    if (c >= 6'o22 && c <= 6'o31) begin
                        g = single(8'h41 + c);
                    end else if (c >= 6'o41 && c <= 6'o51) begin
                        g = single(8'h29 + c);
                    end else if (c >= 6'o61 && c <= 6'o71) begin
                        g = single(8'h10 + c);
                    end
                end
            endcase
        end
        // The dotted halves replace a handful of entries.
        if (idx[7]) begin
            case (idx[6:0])
                7'o000, 7'o100: g = {3'd2, 40'hC2B7_000000};
                7'o021:         g = {3'd4, 40'hC2B7CCB7_00};
                7'o033:         g = single(8'h3B);
                7'o036, 7'o136: g = {3'd3, 40'hC2B709_0000};
                7'o043:         g = {3'd2, 40'hC580_000000};
                7'o073:         g = single(8'h3A);
                7'o077, 7'o177: g = {3'd3, 40'hC2B70A_0000};
                7'o140:         g = {3'd4, 40'hC2B7CCB2_00};
                7'o143:         g = {3'd2, 40'hC4BF_000000};
                7'o156:         g = {3'd5, 40'hC2B7E28392};
                default: ;
            endcase
        end
        return g;
    endfunction

    // Update the mode flags for an accepted tape code and queue its bytes.
    function void note_code(bit [7:0] code);
        bit [7:0]  idx;
        bit [42:0] g;
        int        n;
        codes_taken++;
        if (code == tc2u8_pkg::CODE_UPPER) begin
            shift_upper = 1'b1;
            return;
        end
        if (code == tc2u8_pkg::CODE_LOWER) begin
            shift_upper = 1'b0;
            return;
        end
        if (code == tc2u8_pkg::CODE_RIB_A || code == tc2u8_pkg::CODE_RIB_B) begin
            return;
        end
        idx = code | {dot_pending, shift_upper, 6'b0};
        if (idx[6:0] == tc2u8_pkg::CODE_DOT) begin
            dot_pending = 1'b1;
            dots_marked++;
            return;
        end
        g = glyph(idx);
        n = int'(g[42:40]);
        for (int k = 0; k < n; k++) begin
            byte_q.push_back({k == n - 1, g[39 - 8 * k -: 8]});
        end
        if (n == 0) begin
            blank_chars++;
        end else begin
            chars_printed++;
        end
        dot_pending = 1'b0;
    endfunction

    // Compare one output item against the oldest expected byte.
    function void check_byte(bit [7:0] data, bit last);
        bit [8:0] want;
        bytes_checked++;
        if (byte_q.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("[%0t] unexpected output byte %h last %b", $time, data, last);
            end
            return;
        end
        want = byte_q.pop_front();
        if (want != {last, data}) begin
            errors++;
            if (errors <= 10) begin
                $display("[%0t] byte mismatch: expected %h last %b, got %h last %b",
                         $time, want[7:0], want[8], data, last);
            end
        end
    endfunction

    function int pending();
        return byte_q.size();
    endfunction
endclass

module tb_tape_code_to_utf8_converter_unit;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Idling switch shared by both sides, and a long receiver hold-off request.
    bit idle_on     = 1'b1;
    int rx_hold_req = 0;

    Utf8Scoreboard text_sb;

    // Shift, dot, ribbon, empty entries, the longest strings and high bytes.
    bit [7:0] directed_codes [24] = '{
        8'o000, 8'o001, 8'o056, 8'o073, 8'o012,
        8'o040, 8'o021, 8'o040, 8'o012, 8'o021,
        tc2u8_pkg::CODE_RIB_A, tc2u8_pkg::CODE_RIB_B,
        8'o040, tc2u8_pkg::CODE_UPPER, 8'o056,
        8'o004, 8'o040, 8'o073,
        tc2u8_pkg::CODE_LOWER, 8'o377, 8'o200, 8'o240, 8'o100, 8'o277
    };

    tape_code_to_utf8_converter_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Length of an idle stretch: mostly none, often short, now and then long.
    function automatic int idle_len();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Mostly plain six-bit characters, with shifts, dots, ribbon codes and
    // arbitrary bytes mixed in.
    function automatic bit [7:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58) begin
            return 8'($urandom_range(0, 63));
        end else if (r < 66) begin
            return tc2u8_pkg::CODE_UPPER;
        end else if (r < 74) begin
            return tc2u8_pkg::CODE_LOWER;
        end else if (r < 84) begin
            return {1'b0, tc2u8_pkg::CODE_DOT};
        end else if (r < 88) begin
            return ($urandom_range(0, 1) != 0) ? tc2u8_pkg::CODE_RIB_A
                                                : tc2u8_pkg::CODE_RIB_B;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one tape code after an optional gap and wait until it is taken.
    task automatic send_code(input bit [7:0] code, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge clk); while (!s_tready);
        text_sb.note_code(code);
    endtask

    // Wait until every queued byte has come out.
    task automatic wait_drain();
        while (text_sb.pending() != 0) @(posedge clk);
    endtask

    // Output side: check each accepted item and pick the next ready value.
    initial begin : rx_side
        int stall_left;
        int n;
        stall_left = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                text_sb.check_byte(m_tdata, m_tlast);
            end
            if (rx_hold_req > 0) begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                n = idle_len();
                m_tready <= (n == 0);
                if (n > 0) begin
                    stall_left = n - 1;
                end
            end
        end
    end

    // Stimulus and end of test.
    initial begin : tx_side
        int       counted;
        bit [7:0] code;
        text_sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed codes.
        foreach (directed_codes[i]) begin
            send_code(directed_codes[i], idle_len());
        end

        // Let the output run dry before the next phase.
        s_tvalid <= 1'b0;
        wait_drain();
        @(posedge clk);

        // Hold the receiver off while characters keep coming, so the block
        // backs up into its input.
        rx_hold_req = 150;
        for (int i = 0; i < 30; i++) begin
            send_code(8'($urandom_range(0, 63)), 0);
        end

        // Random codes; the middle stretch runs with no idling at all.
        counted = 0;
        while (counted < 330) begin
            idle_on = !(counted >= 120 && counted < 180);
            code = pick_code();
            send_code(code, idle_len());
            if (code != tc2u8_pkg::CODE_RIB_A && code != tc2u8_pkg::CODE_RIB_B) begin
                counted++;
            end
        end
        idle_on = 1'b1;
        s_tvalid <= 1'b0;

        wait_drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d tape codes: %0d printable characters, %0d empty entries, %0d dots.",
                 text_sb.codes_taken, text_sb.chars_printed, text_sb.blank_chars,
                 text_sb.dots_marked);
        $display("Checked %0d UTF-8 bytes; %0d mismatches.", text_sb.bytes_checked,
                 text_sb.errors);
        if (text_sb.errors == 0 && text_sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin : watchdog
        #20_000_000;
        $display("Timeout with %0d bytes still expected.", text_sb.pending());
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/tc2u8_pkg.sv
design/tc2u8_mode.sv
design/tc2u8_rom.sv
design/tc2u8_ser.sv
design/tape_code_to_utf8_converter_unit.sv
tb/tb_tape_code_to_utf8_converter_unit.sv
